>>> rtl/multi_mode_3x3_window_filter_macros.svh
// Assertion macros for the multi-mode 3x3 window filter.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
// Under SYNTHESIS the macros expand to nothing.
`ifndef MULTI_MODE_3X3_WINDOW_FILTER_MACROS_SVH
`define MULTI_MODE_3X3_WINDOW_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/mm3f_pkg.sv
// Shared types, mode codes and fixed-point constants of the 3x3 window filter.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package mm3f_pkg;

    typedef logic [7:0] pix_t;

    // Window in row-major order, element 0 is top left
    typedef pix_t [8:0] window_t;

    // Filter mode codes
    localparam logic [2:0] MODE_EMBOSS   = 3'd0;
    localparam logic [2:0] MODE_SHARPEN  = 3'd1;
    localparam logic [2:0] MODE_BLUR     = 3'd2;
    localparam logic [2:0] MODE_FREICHEN = 3'd3;
    localparam logic [2:0] MODE_DIFF     = 3'd4;
    localparam logic [2:0] MODE_MEDIAN   = 3'd5;
    localparam logic [2:0] MODE_GAUSS    = 3'd6;
    localparam logic [2:0] MODE_UNUSED   = 3'd7;

    localparam pix_t PIX_MAX    = 8'd255;
    localparam pix_t EMBOSS_OFS = 8'd128;
    localparam pix_t DIFF_OFS   = 8'd60;

    // sqrt(2) in Q16, rounded to nearest
    localparam logic signed [17:0] SQRT2_Q16 = 18'sd92682;
    // Q16 one half for round half up
    localparam logic [24:0] Q16_HALF = 25'd32768;
    // 255.0 in Q16, upper clamp of each Frei-Chen gradient
    localparam logic [23:0] FC_CLAMP_MAX = 24'd16711680;
    // ceil(2^16 / 18): exact floor(x / 18) for x below 4600
    localparam logic [11:0] BLUR_RECIP = 12'd3641;

    // Per-mode results of the arithmetic datapath at the last shared stage
    typedef struct packed {
        pix_t        emboss;
        pix_t        sharpen;
        pix_t        blur;
        pix_t        diff;
        pix_t        gauss;
        logic [23:0] fc_r;
        logic [23:0] fc_c;
    } lin_res_t;

    function automatic pix_t pix_min(pix_t a, pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t pix_max(pix_t a, pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t pix_med3(pix_t a, pix_t b, pix_t c);
        return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
    endfunction

endpackage

`default_nettype wire

>>> rtl/mm3f_median.sv
// Three-stage median-of-nine network: row sort, column reduce, final median of three.
// Depends on mm3f_pkg for pixel types and min/max helpers.
`default_nettype none

module mm3f_median
    import mm3f_pkg::*;
(
    input  wire logic    clk,
    input  wire window_t win,
    output pix_t         median
);

    pix_t row_lo_reg  [3];
    pix_t row_mid_reg [3];
    pix_t row_hi_reg  [3];
    pix_t row_lo_next [3];
    pix_t row_mid_next[3];
    pix_t row_hi_next [3];

    pix_t max_lo_reg, max_lo_next;
    pix_t med_mid_reg, med_mid_next;
    pix_t min_hi_reg, min_hi_next;

    pix_t median_reg, median_next;

    // Sort each row into low, middle and high
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_lo_next[r]  = pix_min(pix_min(win[3*r], win[3*r+1]), win[3*r+2]);
            row_hi_next[r]  = pix_max(pix_max(win[3*r], win[3*r+1]), win[3*r+2]);
            row_mid_next[r] = pix_med3(win[3*r], win[3*r+1], win[3*r+2]);
        end
    end

    // Reduce across rows: largest low, middle of middles, smallest high
    always_comb
    begin
        max_lo_next  = pix_max(pix_max(row_lo_reg[0], row_lo_reg[1]), row_lo_reg[2]);
        med_mid_next = pix_med3(row_mid_reg[0], row_mid_reg[1], row_mid_reg[2]);
        min_hi_next  = pix_min(pix_min(row_hi_reg[0], row_hi_reg[1]), row_hi_reg[2]);
    end

    // Median of the three survivors is the median of all nine
    always_comb
    begin
        median_next = pix_med3(max_lo_reg, med_mid_reg, min_hi_reg);
    end

    // Advance the network
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_lo_reg[r]  <= row_lo_next[r];
            row_mid_reg[r] <= row_mid_next[r];
            row_hi_reg[r]  <= row_hi_next[r];
        end
        max_lo_reg  <= max_lo_next;
        med_mid_reg <= med_mid_next;
        min_hi_reg  <= min_hi_next;
        median_reg  <= median_next;
    end

    assign median = median_reg;

endmodule

`default_nettype wire

>>> rtl/mm3f_lin.sv
// Three-stage arithmetic datapath: pre-add, multiply and clamp for the
// emboss, sharpen, blur, Frei-Chen, difference and Gaussian modes.
// Depends on mm3f_pkg for types and fixed-point constants.
`default_nettype none

module mm3f_lin
    import mm3f_pkg::*;
(
    input  wire logic    clk,
    input  wire window_t win,
    output lin_res_t     res
);

    // Stage 2: sums, differences, absolute differences
    logic signed [8:0]  emb_d_reg, emb_d_next;
    logic [11:0]        sum9_reg, sum9_next;
    logic [11:0]        gsum_reg, gsum_next;
    pix_t               centre_reg, centre_next;
    logic signed [9:0]  fc_ar_reg, fc_ar_next;
    logic signed [8:0]  fc_br_reg, fc_br_next;
    logic signed [9:0]  fc_ac_reg, fc_ac_next;
    logic signed [8:0]  fc_bc_reg, fc_bc_next;
    pix_t               adiff_reg [4];
    pix_t               adiff_next[4];

    // Stage 3: products and partial results
    pix_t               emb_s3_reg, emb_s3_next;
    pix_t               sharp_s3_reg, sharp_s3_next;
    logic [23:0]        blur_prod_reg, blur_prod_next;
    logic signed [9:0]  fc_ar_s3_reg;
    logic signed [9:0]  fc_ac_s3_reg;
    logic signed [26:0] fc_pr_reg, fc_pr_next;
    logic signed [26:0] fc_pc_reg, fc_pc_next;
    pix_t               diff_max_reg, diff_max_next;
    logic [11:0]        gsum_s3_reg;

    // Stage 4: final per-mode values
    lin_res_t           res_reg, res_next;

    logic [12:0]        blur_x;
    logic signed [12:0] sharp_v;
    logic [8:0]         diff_ofs;
    logic signed [26:0] fc_r_raw;
    logic signed [26:0] fc_c_raw;

    function automatic pix_t abs_diff(pix_t a, pix_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Clamp a signed Q16 gradient to 0..255.0
    function automatic logic [23:0] clamp_q16(logic signed [26:0] v);
        logic [23:0] r;
        if (v < 0)
        begin
            r = 24'd0;
        end
        else if (v > $signed({3'b000, FC_CLAMP_MAX}))
        begin
            r = FC_CLAMP_MAX;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Stage 2 pre-add
    always_comb
    begin
        emb_d_next  = $signed({1'b0, win[8]}) - $signed({1'b0, win[0]});
        sum9_next   = 12'(win[0]) + 12'(win[1]) + 12'(win[2])
                    + 12'(win[3]) + 12'(win[4]) + 12'(win[5])
                    + 12'(win[6]) + 12'(win[7]) + 12'(win[8]);
        gsum_next   = 12'(win[0]) + 12'(win[2]) + 12'(win[6]) + 12'(win[8])
                    + {3'b000, win[1], 1'b0} + {3'b000, win[3], 1'b0}
                    + {3'b000, win[5], 1'b0} + {3'b000, win[7], 1'b0}
                    + {2'b00, win[4], 2'b00};
        centre_next = win[4];
        fc_ar_next  = 10'(win[0]) - 10'(win[2]) + 10'(win[6]) - 10'(win[8]);
        fc_br_next  = 9'(win[3]) - 9'(win[5]);
        fc_ac_next  = 10'(win[6]) + 10'(win[8]) - 10'(win[0]) - 10'(win[2]);
        fc_bc_next  = 9'(win[7]) - 9'(win[1]);
        adiff_next[0] = abs_diff(win[8], win[0]);
        adiff_next[1] = abs_diff(win[7], win[1]);
        adiff_next[2] = abs_diff(win[6], win[2]);
        adiff_next[3] = abs_diff(win[3], win[5]);
    end

    // Stage 3: emboss and sharpen clamp, blur and root-2 multiplies, max tree
    always_comb
    begin
        if (emb_d_reg <= 0)
        begin
            emb_s3_next = EMBOSS_OFS;
        end
        else if (emb_d_reg >= 9'sd127)
        begin
            emb_s3_next = PIX_MAX;
        end
        else
        begin
            emb_s3_next = emb_d_reg[7:0] + EMBOSS_OFS;
        end

        // 10 * centre minus the full sum
        sharp_v = 13'({centre_reg, 3'b000}) + 13'({centre_reg, 1'b0}) - 13'(sum9_reg);
        if (sharp_v < 0)
        begin
            sharp_s3_next = 8'd0;
        end
        else if (sharp_v > 13'sd255)
        begin
            sharp_s3_next = PIX_MAX;
        end
        else
        begin
            sharp_s3_next = sharp_v[7:0];
        end

        // Round half up of sum / 9 is floor((2 * sum + 9) / 18)
        blur_x         = {sum9_reg, 1'b0} + 13'd9;
        blur_prod_next = 24'(blur_x) * 24'(BLUR_RECIP);

        fc_pr_next = 27'(fc_br_reg) * 27'(SQRT2_Q16);
        fc_pc_next = 27'(fc_bc_reg) * 27'(SQRT2_Q16);

        diff_max_next = pix_max(pix_max(adiff_reg[0], adiff_reg[1]),
                                pix_max(adiff_reg[2], adiff_reg[3]));
    end

    // Stage 4: finish each mode
    always_comb
    begin
        res_next.emboss  = emb_s3_reg;
        res_next.sharpen = sharp_s3_reg;
        res_next.blur    = blur_prod_reg[23:16];

        diff_ofs = 9'(diff_max_reg) + 9'(DIFF_OFS);
        res_next.diff = diff_ofs[8] ? PIX_MAX : diff_ofs[7:0];

        res_next.gauss = 8'((gsum_s3_reg + 12'd8) >> 4);

        fc_r_raw = $signed({fc_ar_s3_reg[9], fc_ar_s3_reg, 16'h0000}) + fc_pr_reg;
        fc_c_raw = $signed({fc_ac_s3_reg[9], fc_ac_s3_reg, 16'h0000}) + fc_pc_reg;
        res_next.fc_r = clamp_q16(fc_r_raw);
        res_next.fc_c = clamp_q16(fc_c_raw);
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        emb_d_reg  <= emb_d_next;
        sum9_reg   <= sum9_next;
        gsum_reg   <= gsum_next;
        centre_reg <= centre_next;
        fc_ar_reg  <= fc_ar_next;
        fc_br_reg  <= fc_br_next;
        fc_ac_reg  <= fc_ac_next;
        fc_bc_reg  <= fc_bc_next;
        for (int i = 0; i < 4; i++)
        begin
            adiff_reg[i] <= adiff_next[i];
        end

        emb_s3_reg    <= emb_s3_next;
        sharp_s3_reg  <= sharp_s3_next;
        blur_prod_reg <= blur_prod_next;
        fc_ar_s3_reg  <= fc_ar_reg;
        fc_ac_s3_reg  <= fc_ac_reg;
        fc_pr_reg     <= fc_pr_next;
        fc_pc_reg     <= fc_pc_next;
        diff_max_reg  <= diff_max_next;
        gsum_s3_reg   <= gsum_reg;

        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> rtl/multi_mode_3x3_window_filter.sv
// Multi-mode 3x3 window filter top level: input register, mode register, valid
// pipeline, Frei-Chen final sum and mode select; uses mm3f_lin and mm3f_median.
// An item is carried through the input register, the mm3f_lin or mm3f_median stages
// and the output register to its result strobe. Throughput: one window per cycle, set
// by the five-register pipeline; busy stays low. Reset clears the valid pipe
// and sets filter_mode to emboss; results cannot be held off.
`default_nettype none

`include "multi_mode_3x3_window_filter_macros.svh"

module multi_mode_3x3_window_filter
    import mm3f_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_wdata,
    input  wire logic [7:0] pix_top_left,
    input  wire logic [7:0] pix_top_mid,
    input  wire logic [7:0] pix_top_right,
    input  wire logic [7:0] pix_mid_left,
    input  wire logic [7:0] pix_centre,
    input  wire logic [7:0] pix_mid_right,
    input  wire logic [7:0] pix_bot_left,
    input  wire logic [7:0] pix_bot_mid,
    input  wire logic [7:0] pix_bot_right,
    output logic [7:0]      out_pixel,
    output logic            result_valid
);

    logic [2:0] filter_mode_reg, filter_mode_next;

    window_t    win_s1_reg, win_s1_next;
    logic       valid_s1_reg, valid_s2_reg, valid_s3_reg, valid_s4_reg;
    logic [2:0] mode_s1_reg, mode_s2_reg, mode_s3_reg, mode_s4_reg;

    lin_res_t   lin_res;
    pix_t       median;

    logic [24:0] fc_sum;
    pix_t        fc_pix;
    pix_t        out_pixel_reg, out_pixel_next;
    logic        result_valid_reg;

    // The pipeline takes a window every cycle
    assign busy = 1'b0;

    // Mode register write
    always_comb
    begin
        filter_mode_next = cfg_we ? cfg_wdata : filter_mode_reg;
    end

    // Pack the window ports, row-major
    always_comb
    begin
        win_s1_next = {pix_bot_right, pix_bot_mid, pix_bot_left,
                       pix_mid_right, pix_centre,  pix_mid_left,
                       pix_top_right, pix_top_mid, pix_top_left};
    end

    // Hold the window of the latest transfer
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            win_s1_reg <= win_s1_next;
        end
    end

    // Control: mode register, valid and mode travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg  <= MODE_EMBOSS;
            valid_s1_reg     <= 1'b0;
            valid_s2_reg     <= 1'b0;
            valid_s3_reg     <= 1'b0;
            valid_s4_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            mode_s1_reg      <= MODE_EMBOSS;
            mode_s2_reg      <= MODE_EMBOSS;
            mode_s3_reg      <= MODE_EMBOSS;
            mode_s4_reg      <= MODE_EMBOSS;
        end
        else
        begin
            filter_mode_reg  <= filter_mode_next;
            valid_s1_reg     <= start;
            valid_s2_reg     <= valid_s1_reg;
            valid_s3_reg     <= valid_s2_reg;
            valid_s4_reg     <= valid_s3_reg;
            result_valid_reg <= valid_s4_reg;
            mode_s1_reg      <= filter_mode_reg;
            mode_s2_reg      <= mode_s1_reg;
            mode_s3_reg      <= mode_s2_reg;
            mode_s4_reg      <= mode_s3_reg;
        end
    end

    mm3f_lin u_lin (
        .clk (clk),
        .win (win_s1_reg),
        .res (lin_res)
    );

    mm3f_median u_median (
        .clk    (clk),
        .win    (win_s1_reg),
        .median (median)
    );

    // Frei-Chen: add clamped gradients, round half up, clamp to a pixel
    always_comb
    begin
        fc_sum = 25'(lin_res.fc_r) + 25'(lin_res.fc_c) + Q16_HALF;
        fc_pix = fc_sum[24] ? PIX_MAX : fc_sum[23:16];
    end

    // Select the result of the item's mode
    always_comb
    begin
        unique case (mode_s4_reg)
            MODE_EMBOSS:   out_pixel_next = lin_res.emboss;
            MODE_SHARPEN:  out_pixel_next = lin_res.sharpen;
            MODE_BLUR:     out_pixel_next = lin_res.blur;
            MODE_FREICHEN: out_pixel_next = fc_pix;
            MODE_DIFF:     out_pixel_next = lin_res.diff;
            MODE_MEDIAN:   out_pixel_next = median;
            MODE_GAUSS:    out_pixel_next = lin_res.gauss;
            default:       out_pixel_next = 8'd0;
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        out_pixel_reg <= out_pixel_next;
    end

    assign out_pixel    = out_pixel_reg;
    assign result_valid = result_valid_reg;

    // Each transfer enters the valid pipe on the next edge
    `ASSERT_NEXT(a_start_enters, clk, rst_n, start, valid_s1_reg)
    // Every result strobe traces back through the valid pipe to an earlier transfer
    `ASSERT_IMPLY(a_result_origin, clk, rst_n, result_valid, $past(start, 5))
    // Emboss never drops below its offset
    `ASSERT_IMPLY(a_emboss_floor, clk, rst_n, result_valid && $past(mode_s4_reg == MODE_EMBOSS), out_pixel[7])
    // Difference filter never drops below its offset
    `ASSERT_IMPLY(a_diff_floor, clk, rst_n, result_valid && $past(mode_s4_reg == MODE_DIFF), out_pixel >= DIFF_OFS)
    // Unused mode gives zero
    `ASSERT_IMPLY(a_unused_zero, clk, rst_n, result_valid && $past(mode_s4_reg == MODE_UNUSED), out_pixel == 8'd0)

endmodule

`default_nettype wire

>>> verif/filter_checker.sv
// Checker for the multi-mode 3x3 window filter: tracks the mode register, predicts each
// filtered pixel and compares it with the result transfer. Depends on mm3f_pkg only.
`default_nettype none

module filter_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_wdata,
    input  wire logic [7:0] pix_top_left,
    input  wire logic [7:0] pix_top_mid,
    input  wire logic [7:0] pix_top_right,
    input  wire logic [7:0] pix_mid_left,
    input  wire logic [7:0] pix_centre,
    input  wire logic [7:0] pix_mid_right,
    input  wire logic [7:0] pix_bot_left,
    input  wire logic [7:0] pix_bot_mid,
    input  wire logic [7:0] pix_bot_right,
    input  wire logic [7:0] out_pixel,
    input  wire logic       result_valid,
    output int              error_count,
    output int              pixels_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import mm3f_pkg::*;

    localparam longint FIX_ONE   = 65536;
    localparam longint FIX_ROOT2 = 92682;
    localparam longint GRAD_MAX  = 255 * 65536;
    localparam longint PIXEL_TOP = 255;

    logic [2:0] current_mode;
    pix_t       expected_pixels[$];

    function automatic longint clamp_to_pixel(longint v);
        if (v < 0)
            return 0;
        if (v > PIXEL_TOP)
            return PIXEL_TOP;
        return v;
    endfunction

    function automatic longint clamp_gradient(longint v);
        if (v < 0)
            return 0;
        if (v > GRAD_MAX)
            return GRAD_MAX;
        return v;
    endfunction

    function automatic int pixel_gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Filtered pixel of one window under the given mode
    function automatic pix_t filter_pixel(logic [2:0] mode, window_t w);
        int     p[9];
        int     sorted[9];
        int     sum;
        int     wsum;
        int     widest;
        int     k;
        int     j;
        int     v;
        longint grad_r;
        longint grad_c;
        longint res;
        for (k = 0; k < 9; k++)
            p[k] = int'(w[k]);
        sum = 0;
        for (k = 0; k < 9; k++)
            sum += p[k];
        res = 0;
        case (mode)
            MODE_EMBOSS:
                res = clamp_to_pixel(clamp_to_pixel(p[8] - p[0]) + 128);
            MODE_SHARPEN:
                res = clamp_to_pixel(10 * p[4] - sum);
            MODE_BLUR:
                res = clamp_to_pixel((2 * sum + 9) / 18);
            MODE_FREICHEN:
            begin
                grad_r = longint'(p[0] - p[2] + p[6] - p[8]) * FIX_ONE
                       + longint'(p[3] - p[5]) * FIX_ROOT2;
                grad_c = longint'(p[6] + p[8] - p[0] - p[2]) * FIX_ONE
                       + longint'(p[7] - p[1]) * FIX_ROOT2;
                grad_r = clamp_gradient(grad_r);
                grad_c = clamp_gradient(grad_c);
                res = clamp_to_pixel((grad_r + grad_c + FIX_ONE / 2) / FIX_ONE);
            end
            MODE_DIFF:
            begin
                widest = pixel_gap(p[8], p[0]);
                if (pixel_gap(p[7], p[1]) > widest)
                    widest = pixel_gap(p[7], p[1]);
                if (pixel_gap(p[6], p[2]) > widest)
                    widest = pixel_gap(p[6], p[2]);
                if (pixel_gap(p[3], p[5]) > widest)
                    widest = pixel_gap(p[3], p[5]);
                res = clamp_to_pixel(widest + 60);
            end
            MODE_MEDIAN:
            begin
                // insertion sort, take the middle element
                for (k = 0; k < 9; k++)
                    sorted[k] = p[k];
                for (k = 1; k < 9; k++)
                begin
                    v = sorted[k];
                    j = k - 1;
                    while (j >= 0 && sorted[j] > v)
                    begin
                        sorted[j + 1] = sorted[j];
                        j--;
                    end
                    sorted[j + 1] = v;
                end
                res = sorted[4];
            end
            MODE_GAUSS:
            begin
                wsum = p[0] + 2 * p[1] + p[2]
                     + 2 * p[3] + 4 * p[4] + 2 * p[5]
                     + p[6] + 2 * p[7] + p[8];
                res = clamp_to_pixel((wsum + 8) / 16);
            end
            default:
                res = 0;
        endcase
        return pix_t'(res);
    endfunction

    initial
    begin
        error_count      = 0;
        pixels_in_flight = 0;
    end

    // Check result transfers, queue predictions for window transfers, track the mode
    always @(posedge clk or negedge rst_n)
    begin : track_transfers
        window_t win;
        pix_t    want;
        if (!rst_n)
        begin
            current_mode = MODE_EMBOSS;
            expected_pixels.delete();
            pixels_in_flight = 0;
        end
        else
        begin
            if (result_valid === 1'b1)
            begin
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $error("out_pixel: expected none, actual %0d", out_pixel);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_pixel !== want)
                    begin
                        error_count++;
                        $error("out_pixel: expected %0d, actual %0d", want, out_pixel);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                win[0] = pix_top_left;
                win[1] = pix_top_mid;
                win[2] = pix_top_right;
                win[3] = pix_mid_left;
                win[4] = pix_centre;
                win[5] = pix_mid_right;
                win[6] = pix_bot_left;
                win[7] = pix_bot_mid;
                win[8] = pix_bot_right;
                expected_pixels.push_back(filter_pixel(current_mode, win));
            end
            if (cfg_we === 1'b1)
                current_mode = cfg_wdata;
            pixels_in_flight = expected_pixels.size();
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Top of the 3x3 window filter testbench: clock, reset, mode writes and window stimulus.
// Depends on mm3f_pkg, filter_checker and the multi_mode_3x3_window_filter RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mm3f_pkg::*;

    localparam int RESULT_LATENCY = 5;
    localparam int STALL_LIMIT    = 2000;
    localparam int GAP_MAX        = 12;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 125;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       cfg_we;
    logic [2:0] cfg_wdata;
    logic [7:0] pix_top_left;
    logic [7:0] pix_top_mid;
    logic [7:0] pix_top_right;
    logic [7:0] pix_mid_left;
    logic [7:0] pix_centre;
    logic [7:0] pix_mid_right;
    logic [7:0] pix_bot_left;
    logic [7:0] pix_bot_mid;
    logic [7:0] pix_bot_right;
    logic [7:0] out_pixel;
    logic       result_valid;
    int         error_count;
    int         pixels_in_flight;
    int         stall_cycles = 0;

    logic [2:0] mode_list[8] = '{MODE_EMBOSS, MODE_SHARPEN, MODE_BLUR, MODE_FREICHEN,
                                 MODE_DIFF, MODE_MEDIAN, MODE_GAUSS, MODE_UNUSED};

    multi_mode_3x3_window_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pix_top_left  (pix_top_left),
        .pix_top_mid   (pix_top_mid),
        .pix_top_right (pix_top_right),
        .pix_mid_left  (pix_mid_left),
        .pix_centre    (pix_centre),
        .pix_mid_right (pix_mid_right),
        .pix_bot_left  (pix_bot_left),
        .pix_bot_mid   (pix_bot_mid),
        .pix_bot_right (pix_bot_right),
        .out_pixel     (out_pixel),
        .result_valid  (result_valid)
    );

    filter_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .pix_top_left     (pix_top_left),
        .pix_top_mid      (pix_top_mid),
        .pix_top_right    (pix_top_right),
        .pix_mid_left     (pix_mid_left),
        .pix_centre       (pix_centre),
        .pix_mid_right    (pix_mid_right),
        .pix_bot_left     (pix_bot_left),
        .pix_bot_mid      (pix_bot_mid),
        .pix_bot_right    (pix_bot_right),
        .out_pixel        (out_pixel),
        .result_valid     (result_valid),
        .error_count      (error_count),
        .pixels_in_flight (pixels_in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Random window: uniform noise, smooth patch, black/white, two-level edge or flat
    function automatic window_t random_window();
        window_t w;
        int      shape;
        int      base;
        int      spread;
        int      by_row;
        int      k;
        int      v;
        shape  = $urandom_range(0, 9);
        base   = $urandom_range(0, 255);
        spread = $urandom_range(0, 24);
        by_row = $urandom_range(0, 1);
        for (k = 0; k < 9; k++)
        begin
            case (shape)
                0, 1, 2, 3:
                    v = $urandom_range(0, 255);
                4, 5, 6:
                begin
                    v = int'($urandom_range(0, 2 * spread));
                    v = base + v - spread;
                end
                7:
                    v = $urandom_range(0, 1) ? 255 : 0;
                8:
                begin
                    v = int'($urandom_range(0, 8));
                    if (((by_row != 0) ? k / 3 : k % 3) > 0)
                        v = base + v - 4;
                    else
                        v = 255 - base + v - 4;
                end
                default:
                    v = base;
            endcase
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            w[k] = 8'(v);
        end
        return w;
    endfunction

    // Present one window after an idle gap and hold it until it transfers
    task automatic send_window(window_t w, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        pix_top_left  <= w[0];
        pix_top_mid   <= w[1];
        pix_top_right <= w[2];
        pix_mid_left  <= w[3];
        pix_centre    <= w[4];
        pix_mid_right <= w[5];
        pix_bot_left  <= w[6];
        pix_bot_mid   <= w[7];
        pix_bot_right <= w[8];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // Drop start, wait for every expected pixel, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        while (pixels_in_flight != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_mode(logic [2:0] mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        window_t    w;
        int         m;
        int         k;
        int         n;
        int         gappy;
        logic [2:0] mode;

        rst_n         = 1'b0;
        start         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = MODE_EMBOSS;
        pix_top_left  = '0;
        pix_top_mid   = '0;
        pix_top_right = '0;
        pix_mid_left  = '0;
        pix_centre    = '0;
        pix_mid_right = '0;
        pix_bot_left  = '0;
        pix_bot_mid   = '0;
        pix_bot_right = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: black, white and a ramp under every mode, emboss from reset
        for (m = 0; m < 8; m++)
        begin
            if (mode_list[m] != MODE_EMBOSS)
            begin
                drain();
                write_mode(mode_list[m]);
            end
            send_window('0, 0);
            send_window({9{8'hFF}}, 0);
            for (k = 0; k < 9; k++)
                w[k] = (k == 8) ? 8'hFF : 8'(k * 32);
            send_window(w, 1);
        end

        // Random phases: every mode once, extremes included, then random modes
        for (n = 0; n < PHASES; n++)
        begin
            mode  = (n < 8) ? mode_list[7 - n] : mode_list[$urandom_range(0, 7)];
            gappy = $urandom_range(0, 3);
            drain();
            write_mode(mode);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_window(random_window(), (gappy != 0) ? $urandom_range(0, GAP_MAX) : 0);
        end

        drain();
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/mm3f_pkg.sv
rtl/mm3f_median.sv
rtl/mm3f_lin.sv
rtl/multi_mode_3x3_window_filter.sv
verif/filter_checker.sv
verif/tb_top.sv
